// ===== hw/rtl/rpvc_pkg.sv =====
// Shared constants and types for the range paint visible count block.
package rpvc_pkg;
  localparam int LEAVES     = 2048;
  localparam int TREE_NODES = 8192;
  localparam int MAX_COLORS = 1023;
  localparam int LEAF_W  = $clog2(LEAVES);
  localparam int NODE_W  = $clog2(TREE_NODES);
  localparam int FNODE_W = NODE_W + 2;  // room for 2*x+2 of the last node
  localparam int COLOR_W = 10;
  localparam int STACK_D = 16;
  localparam int SP_W    = $clog2(STACK_D) + 1;

  localparam logic [1:0] MODE_PAINT = 2'd0;
  localparam logic [1:0] MODE_COUNT = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // one pending walk frame: node and its span
  typedef struct packed {
    logic [FNODE_W-1:0] node;
    logic [LEAF_W-1:0]  lo;
    logic [LEAF_W-1:0]  hi;
  } frame_t;

  // one-hot sequencer states
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLR   = 7'b0000010,
    S_RD    = 7'b0000100,
    S_EVAL  = 7'b0001000,
    S_PUSHA = 7'b0010000,
    S_PUSHB = 7'b0100000,
    S_MARK  = 7'b1000000
  } state_t;
endpackage

// ===== hw/rtl/range_paint_visible_count.sv =====
// Top level: segment tree range paint and distinct color count.
//  beat    | ports                                   | accepted when
//  input   | in_mode in_range_left in_range_right    | start & !busy
//          | in_paint_color                          |
//  result  | out_visible_count                       | out_valid, one-cycle strobe
//  config  | cfg_last_leaf                           | cfg_we, no wait
// Paint: a node outside the range or fully covered is done once read; a partly
// covered node is then cleared, and a color that it held is pushed to both
// children. Count: each node is read and evaluated, and a colored node is
// marked; the result strobes in the cycle after the last node, with busy
// already low. Count walks the tree. Clear and reset: a clearing pass over
// all TREE_NODES (8192) nodes, busy high. Unused mode and paint with color
// zero give no result. The receiver cannot stall.
module range_paint_visible_count
  import rpvc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_mode,
  input  logic [10:0]        in_range_left,
  input  logic [10:0]        in_range_right,
  input  logic [9:0]         in_paint_color,
  output logic               out_valid,
  output logic [9:0]         out_visible_count,
  input  logic               cfg_we,
  input  logic [10:0]        cfg_last_leaf
);
  state_t              state_r, state_nxt;
  logic [LEAF_W-1:0]   last_r;
  logic                is_paint_r;
  logic [LEAF_W-1:0]   left_r, right_r;
  logic [COLOR_W-1:0]  color_r;
  logic [COLOR_W-1:0]  total_r;
  logic [NODE_W-1:0]   clr_r;
  frame_t              stack_r [STACK_D];
  logic [SP_W-1:0]     sp_r;
  frame_t              cur_r;
  logic [COLOR_W-1:0]  pend_col_r;
  logic [FNODE_W-1:0]  pend_node_r;
  logic                out_valid_r;

  logic                t_we;
  logic [NODE_W-1:0]   t_waddr, t_raddr;
  logic [COLOR_W-1:0]  t_wdata, t_rdata;
  logic                s_we, s_wdata, s_rdata;
  logic [COLOR_W-1:0]  s_waddr;
  logic [SP_W-2:0]     sp_idx;
  logic                step_next, descend, walk_end;

  rpvc_tree_ram u_tree (.clk, .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
                        .raddr(t_raddr), .rdata(t_rdata));
  rpvc_seen_ram u_seen (.clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
                        .raddr(t_rdata), .rdata(s_rdata));

  // node decode for the current frame
  logic               in_mem, pend_in_mem, outside, covers, leaf;
  logic [LEAF_W-1:0]  mid;
  logic [LEAF_W:0]    mid_sum;
  logic [FNODE_W-1:0] kid_a, kid_b;
  frame_t             frame_a, frame_b;
  assign in_mem      = (cur_r.node < FNODE_W'(TREE_NODES));
  assign pend_in_mem = (pend_node_r < FNODE_W'(TREE_NODES));
  assign outside = (cur_r.hi < left_r) || (cur_r.lo > right_r);
  assign covers  = (left_r <= cur_r.lo) && (cur_r.hi <= right_r);
  assign leaf    = (cur_r.lo >= cur_r.hi);
  assign mid_sum = {1'b0, cur_r.lo} + {1'b0, cur_r.hi};
  assign mid     = mid_sum[LEAF_W:1];
  assign kid_a   = {cur_r.node[NODE_W:0], 1'b1};
  assign kid_b   = {cur_r.node[NODE_W:0], 1'b0} + FNODE_W'(2);
  assign frame_a = '{node: kid_a, lo: cur_r.lo, hi: mid};
  assign frame_b = '{node: kid_b, lo: mid + LEAF_W'(1), hi: cur_r.hi};
  assign sp_idx  = sp_r[SP_W-2:0];

  // memory port control
  assign t_raddr = cur_r.node[NODE_W-1:0];
  always_comb begin
    t_we = 1'b0; t_waddr = cur_r.node[NODE_W-1:0]; t_wdata = '0;
    s_we = 1'b0; s_waddr = pend_col_r; s_wdata = 1'b1;
    unique case (state_r)
      S_CLR: begin
        t_we = 1'b1; t_waddr = clr_r;
        s_we = (clr_r <= NODE_W'(MAX_COLORS));
        s_waddr = clr_r[COLOR_W-1:0]; s_wdata = 1'b0;
      end
      // fully covered node takes the color
      S_RD: if (is_paint_r && in_mem && !outside && covers) begin
        t_we = 1'b1; t_wdata = color_r;
      end
      // partly covered node is cleared
      S_EVAL: t_we = is_paint_r;
      // old color pushed to both children
      S_PUSHA: begin
        t_we = in_mem; t_wdata = pend_col_r;
      end
      S_PUSHB: begin
        t_we = pend_in_mem; t_waddr = pend_node_r[NODE_W-1:0];
        t_wdata = pend_col_r;
      end
      S_MARK: s_we = !s_rdata;
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    step_next = 1'b0;
    descend   = 1'b0;
    unique case (state_r)
      S_IDLE: if (start) begin
        unique case (in_mode)
          MODE_PAINT: if (in_paint_color != '0) state_nxt = S_RD;
          MODE_COUNT: state_nxt = S_RD;
          MODE_CLEAR: state_nxt = S_CLR;
          default:    state_nxt = S_IDLE;
        endcase
      end
      S_CLR: if (clr_r == NODE_W'(TREE_NODES-1)) state_nxt = S_IDLE;
      S_RD: begin
        if (!in_mem || (is_paint_r && (outside || covers))) step_next = 1'b1;
        else state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (is_paint_r) begin
          descend = 1'b1;
          state_nxt = (t_rdata != '0) ? S_PUSHA : S_RD;
        end else if (t_rdata != '0) state_nxt = S_MARK;
        else if (leaf) step_next = 1'b1;
        else begin
          descend = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_PUSHA: state_nxt = S_PUSHB;
      S_PUSHB: state_nxt = S_RD;
      S_MARK:  step_next = 1'b1;
      default: state_nxt = S_IDLE;
    endcase
    // next frame from the stack, or the walk is over
    if (step_next) state_nxt = (sp_r == '0) ? S_IDLE : S_RD;
  end
  assign walk_end = step_next && (sp_r == '0);

  // walk registers and frame stack
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; clr_r <= '0; sp_r <= '0; total_r <= '0;
      last_r <= '0; out_valid_r <= 1'b0; is_paint_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= walk_end && !is_paint_r;
      if (cfg_we) last_r <= cfg_last_leaf;
      unique case (state_r)
        S_IDLE: if (start) begin
          is_paint_r <= (in_mode == MODE_PAINT);
          left_r <= in_range_left; right_r <= in_range_right;
          color_r <= in_paint_color;
          cur_r <= '{node: '0, lo: '0, hi: last_r};
          sp_r <= '0; clr_r <= '0;
          if (in_mode == MODE_CLEAR) total_r <= '0;
        end
        S_CLR: clr_r <= clr_r + NODE_W'(1);
        S_EVAL: begin
          pend_col_r  <= t_rdata;
          pend_node_r <= kid_b;
        end
        S_MARK: if (!s_rdata && total_r != '1) total_r <= total_r + COLOR_W'(1);
        default: ;
      endcase
      // descend into the left child, the right one waits on the stack
      if (descend) begin
        stack_r[sp_idx] <= frame_b;
        cur_r <= frame_a;
        sp_r  <= sp_r + SP_W'(1);
      end else if (step_next && sp_r != '0) begin
        cur_r <= stack_r[sp_idx - (SP_W-1)'(1)];
        sp_r  <= sp_r - SP_W'(1);
      end
    end
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_visible_count = total_r;

  // checks
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r));
  a_stack_room: assert property (@(posedge clk) disable iff (!rst_n)
    descend |-> (sp_r < SP_W'(STACK_D)));
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid);
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy);
endmodule

// ===== hw/rtl/rpvc_tree_ram.sv =====
// Cover color memory: one write port, one registered read port.
module rpvc_tree_ram
  import rpvc_pkg::*;
(
  input  logic                 clk,
  input  logic                 we,
  input  logic [NODE_W-1:0]    waddr,
  input  logic [COLOR_W-1:0]   wdata,
  input  logic [NODE_W-1:0]    raddr,
  output logic [COLOR_W-1:0]   rdata
);
  logic [COLOR_W-1:0] mem [TREE_NODES];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/rpvc_seen_ram.sv =====
// Color seen marks: one write port, one registered read port.
module rpvc_seen_ram
  import rpvc_pkg::*;
(
  input  logic               clk,
  input  logic               we,
  input  logic [COLOR_W-1:0] waddr,
  input  logic               wdata,
  input  logic [COLOR_W-1:0] raddr,
  output logic               rdata
);
  logic mem [MAX_COLORS+1];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
